// ===== src/stick_deadzone_cursor_mover_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the stick deadzone cursor mover core
// Immediate-implication and next-cycle implication checks with sync reset.
// ---------------------------------------------------------------------------
`ifndef STICK_DEADZONE_CURSOR_MOVER_CORE_ASSERT_SVH
`define STICK_DEADZONE_CURSOR_MOVER_CORE_ASSERT_SVH

// same-cycle implication
`define SDCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdcm assertion failed");

// next-cycle implication
`define SDCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdcm assertion failed");

`endif

// ===== src/sdcm_pkg.sv =====
// ---------------------------------------------------------------------------
// sdcm_pkg
// Types, widths and constants shared by the stick deadzone cursor mover.
// ---------------------------------------------------------------------------
package sdcm_pkg;

   // sizing
   localparam int TimeBits  = 32;
   localparam int CoordBits = 16;

   localparam int AxisW   = 16;
   localparam int DzW     = 15;
   localparam int AbsW    = AxisW + 1;
   localparam int MagW    = 24;            // root with 8 fraction bits
   localparam int MulAW   = MagW;
   localparam int MulBW   = AbsW;
   localparam int ProdW   = MulAW + MulBW;
   localparam int SumW    = 32;            // x*x + y*y
   localparam int RadW    = SumW + 16;     // radicand, sum shifted by 16
   localparam int RemSqW  = MagW + 2;
   localparam int NumW    = ProdW + 2;     // gain 4 applied as shift
   localparam int DenW    = MagW + DzW;
   localparam int QuotW   = 18;
   localparam int DshW    = DenW + QuotW - 1;
   localparam int SubW    = DshW;
   localparam int PlaceW  = 20;
   localparam int CntW    = 5;

   localparam int RootSteps = MagW;
   localparam int QuotSteps = QuotW;

   // ports
   localparam int ReqDataW = 88;
   localparam int RspDataW = 40;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   localparam logic [DzW-1:0] FullScale = 15'd32767;

   // register reset values
   localparam logic [DzW-1:0] DeadZoneRst = 15'd8000;
   localparam logic [15:0]    RepeatRst   = 16'd167;
   localparam logic [15:0]    MaxXRst     = 16'd799;
   localparam logic [15:0]    MaxYRst     = 16'd599;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ENABLED,
      CSR_DEAD_ZONE,
      CSR_REPEAT,
      CSR_MIN_X,
      CSR_MIN_Y,
      CSR_MAX_X,
      CSR_MAX_Y
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SUM,
      ST_ROOT,
      ST_DEN,
      ST_NUMX,
      ST_LDX,
      ST_DIVX,
      ST_LDY,
      ST_DIVY,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      MUL_SQX,
      MUL_SQY,
      MUL_DEN,
      MUL_NUMX,
      MUL_NUMY
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        s_load;
      logic        sq_load;
      logic        sq_step;
      logic        den_load;
      logic        dv_load;
      logic        dv_step;
      logic        qx_save;
   } ctrl_type;

endpackage

// ===== src/sdcm_dp.sv =====
// ---------------------------------------------------------------------------
// sdcm_dp
// Right-stick datapath: one shared multiplier and one shared subtractor,
// used for the squares, the bitwise root and two restoring divides.
// ---------------------------------------------------------------------------
module sdcm_dp (
   input  logic                            clock,
   input  sdcm_pkg::ctrl_type              ctrl,
   input  logic [sdcm_pkg::AxisW-1:0]      rx,
   input  logic [sdcm_pkg::AxisW-1:0]      ry,
   input  logic [sdcm_pkg::DzW-1:0]        dead_zone,
   output logic [sdcm_pkg::QuotW-1:0]      qx,
   output logic [sdcm_pkg::QuotW-1:0]      qy
);

   logic [sdcm_pkg::AbsW-1:0]   ax, ay;
   logic [sdcm_pkg::DzW-1:0]    den_dz;
   logic [sdcm_pkg::MagW-1:0]   diff;
   logic [sdcm_pkg::MulAW-1:0]  mul_a;
   logic [sdcm_pkg::MulBW-1:0]  mul_b;
   logic [sdcm_pkg::ProdW-1:0]  prod_ff, prod_in;
   logic [sdcm_pkg::SumW-1:0]   s_ff;
   logic [sdcm_pkg::RadW-1:0]   sq_x_ff;
   logic [sdcm_pkg::RemSqW-1:0] sq_rem_ff, rem_sh, trial;
   logic [sdcm_pkg::MagW-1:0]   root_ff;
   logic [sdcm_pkg::DenW-1:0]   den_ff;
   logic [sdcm_pkg::NumW-1:0]   dv_rem_ff;
   logic [sdcm_pkg::DshW-1:0]   dsh_ff;
   logic [sdcm_pkg::QuotW-1:0]  q_ff, qx_ff;
   logic [sdcm_pkg::SubW-1:0]   sub_a, sub_b, sub_d;
   logic [sdcm_pkg::SubW:0]     sub_full;
   logic                        ge;

   // magnitudes and deadzone terms
   assign ax     = rx[sdcm_pkg::AxisW-1] ? (17'd0 - {rx[sdcm_pkg::AxisW-1], rx})
                                         : {1'b0, rx};
   assign ay     = ry[sdcm_pkg::AxisW-1] ? (17'd0 - {ry[sdcm_pkg::AxisW-1], ry})
                                         : {1'b0, ry};
   assign den_dz = (dead_zone == sdcm_pkg::FullScale) ? 15'd1
                                                      : sdcm_pkg::FullScale - dead_zone;
   assign diff   = root_ff - {1'b0, dead_zone, 8'd0};

   // shared multiplier operand select
   always_comb begin
      case (ctrl.mul_sel)
         sdcm_pkg::MUL_SQX: begin
            mul_a = sdcm_pkg::MulAW'(ax);
            mul_b = ax;
         end
         sdcm_pkg::MUL_SQY: begin
            mul_a = sdcm_pkg::MulAW'(ay);
            mul_b = ay;
         end
         sdcm_pkg::MUL_DEN: begin
            mul_a = root_ff;
            mul_b = sdcm_pkg::MulBW'(den_dz);
         end
         sdcm_pkg::MUL_NUMX: begin
            mul_a = diff;
            mul_b = ax;
         end
         sdcm_pkg::MUL_NUMY: begin
            mul_a = diff;
            mul_b = ay;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = sdcm_pkg::ProdW'(mul_a) * sdcm_pkg::ProdW'(mul_b);

   // shared subtractor: root trial or divisor compare
   assign rem_sh = {sq_rem_ff[sdcm_pkg::RemSqW-3:0], sq_x_ff[sdcm_pkg::RadW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      if (ctrl.sq_step) begin
         sub_a = sdcm_pkg::SubW'(rem_sh);
         sub_b = sdcm_pkg::SubW'(trial);
      end else begin
         sub_a = sdcm_pkg::SubW'(dv_rem_ff);
         sub_b = dsh_ff;
      end
   end

   assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_d    = sub_full[sdcm_pkg::SubW-1:0];
   assign ge       = ~sub_full[sdcm_pkg::SubW];

   // product, sum of squares and denominator
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.s_load) begin
         s_ff <= prod_ff[sdcm_pkg::SumW-1:0];
      end
      if (ctrl.den_load) begin
         den_ff <= prod_ff[sdcm_pkg::DenW-1:0];
      end
   end

   // square root, two radicand bits per step
   always_ff @(posedge clock) begin
      if (ctrl.sq_load) begin
         sq_x_ff   <= {s_ff + prod_ff[sdcm_pkg::SumW-1:0], 16'd0};
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end else if (ctrl.sq_step) begin
         sq_x_ff <= {sq_x_ff[sdcm_pkg::RadW-3:0], 2'b00};
         if (ge) begin
            sq_rem_ff <= sub_d[sdcm_pkg::RemSqW-1:0];
            root_ff   <= {root_ff[sdcm_pkg::MagW-2:0], 1'b1};
         end else begin
            sq_rem_ff <= rem_sh;
            root_ff   <= {root_ff[sdcm_pkg::MagW-2:0], 1'b0};
         end
      end
   end

   // restoring divide, one quotient bit per step
   always_ff @(posedge clock) begin
      if (ctrl.qx_save) begin
         qx_ff <= q_ff;
      end
      if (ctrl.dv_load) begin
         dv_rem_ff <= {prod_ff, 2'b00};
         dsh_ff    <= {den_ff, {(sdcm_pkg::QuotW-1){1'b0}}};
         q_ff      <= '0;
      end else if (ctrl.dv_step) begin
         if (ge) begin
            dv_rem_ff <= sub_d[sdcm_pkg::NumW-1:0];
         end
         dsh_ff <= {1'b0, dsh_ff[sdcm_pkg::DshW-1:1]};
         q_ff   <= {q_ff[sdcm_pkg::QuotW-2:0], ge};
      end
   end

   assign qx = qx_ff;
   assign qy = q_ff;

endmodule

// ===== src/sdcm_ctrl.sv =====
// ---------------------------------------------------------------------------
// sdcm_ctrl
// Sequencer for the shared datapath: squares, root steps, two divides.
// ---------------------------------------------------------------------------
module sdcm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               go_long,
   input  logic               go_short,
   input  logic               out_free,
   output sdcm_pkg::ctrl_type ctrl,
   output logic               idle,
   output logic               fin
);

   sdcm_pkg::state_type         state_ff, state_in;
   logic [sdcm_pkg::CntW-1:0]   cnt_ff, cnt_in;
   logic                        cnt_zero;

   assign cnt_zero = (cnt_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdcm_pkg::ST_IDLE: begin
            if (go_long) begin
               state_in = sdcm_pkg::ST_SQX;
            end else if (go_short) begin
               state_in = sdcm_pkg::ST_FIN;
            end
         end
         sdcm_pkg::ST_SQX:  state_in = sdcm_pkg::ST_SQY;
         sdcm_pkg::ST_SQY:  state_in = sdcm_pkg::ST_SUM;
         sdcm_pkg::ST_SUM:  state_in = sdcm_pkg::ST_ROOT;
         sdcm_pkg::ST_ROOT: begin
            if (cnt_zero) begin
               state_in = sdcm_pkg::ST_DEN;
            end
         end
         sdcm_pkg::ST_DEN:  state_in = sdcm_pkg::ST_NUMX;
         sdcm_pkg::ST_NUMX: state_in = sdcm_pkg::ST_LDX;
         sdcm_pkg::ST_LDX:  state_in = sdcm_pkg::ST_DIVX;
         sdcm_pkg::ST_DIVX: begin
            if (cnt_zero) begin
               state_in = sdcm_pkg::ST_LDY;
            end
         end
         sdcm_pkg::ST_LDY:  state_in = sdcm_pkg::ST_DIVY;
         sdcm_pkg::ST_DIVY: begin
            if (cnt_zero) begin
               state_in = sdcm_pkg::ST_FIN;
            end
         end
         sdcm_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = sdcm_pkg::ST_IDLE;
            end
         end
         default: state_in = sdcm_pkg::ST_IDLE;
      endcase
   end

   // step counter
   always_comb begin
      case (state_ff)
         sdcm_pkg::ST_SUM:  cnt_in = sdcm_pkg::CntW'(sdcm_pkg::RootSteps - 1);
         sdcm_pkg::ST_LDX,
         sdcm_pkg::ST_LDY:  cnt_in = sdcm_pkg::CntW'(sdcm_pkg::QuotSteps - 1);
         sdcm_pkg::ST_ROOT,
         sdcm_pkg::ST_DIVX,
         sdcm_pkg::ST_DIVY: cnt_in = cnt_ff - 1'b1;
         default:           cnt_in = cnt_ff;
      endcase
   end

   // datapath controls
   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = sdcm_pkg::MUL_SQX;
      case (state_ff)
         sdcm_pkg::ST_SQX: ctrl.mul_sel = sdcm_pkg::MUL_SQX;
         sdcm_pkg::ST_SQY: begin
            ctrl.mul_sel = sdcm_pkg::MUL_SQY;
            ctrl.s_load  = 1'b1;
         end
         sdcm_pkg::ST_SUM:  ctrl.sq_load = 1'b1;
         sdcm_pkg::ST_ROOT: ctrl.sq_step = 1'b1;
         sdcm_pkg::ST_DEN:  ctrl.mul_sel = sdcm_pkg::MUL_DEN;
         sdcm_pkg::ST_NUMX: begin
            ctrl.mul_sel  = sdcm_pkg::MUL_NUMX;
            ctrl.den_load = 1'b1;
         end
         sdcm_pkg::ST_LDX: begin
            ctrl.mul_sel = sdcm_pkg::MUL_NUMY;
            ctrl.dv_load = 1'b1;
         end
         sdcm_pkg::ST_DIVX: begin
            ctrl.mul_sel = sdcm_pkg::MUL_NUMY;
            ctrl.dv_step = 1'b1;
         end
         sdcm_pkg::ST_LDY: begin
            ctrl.mul_sel = sdcm_pkg::MUL_NUMY;
            ctrl.dv_load = 1'b1;
            ctrl.qx_save = 1'b1;
         end
         sdcm_pkg::ST_DIVY: ctrl.dv_step = 1'b1;
         default: ctrl.mul_sel = sdcm_pkg::MUL_SQX;
      endcase
   end

   assign idle = (state_ff == sdcm_pkg::ST_IDLE);
   assign fin  = (state_ff == sdcm_pkg::ST_FIN) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdcm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/stick_deadzone_cursor_mover_core.sv =====
// ---------------------------------------------------------------------------
// stick_deadzone_cursor_mover_core
// Keeps the four stick axes; on ticks emits direction pulses, release-all and
// a cursor warp scaled by the radial deadzone of the right stick.
// ---------------------------------------------------------------------------
//   channel  dir  handshake           payload
//   req      in   req_tvalid/tready   tuser: func; tdata: select, value, time,
//                                     cursor x, cursor y
//   rsp      out  rsp_tvalid/tready   tuser: warp_valid; tdata: pulses, warp xy
//   csr      in   csr_we              csr_index, csr_wdata
//
// Axis items, disabled ticks and ticks with the right stick inside the
// deadzone go from accept straight to the result state, then back to ready.
// Ticks with an active right stick run 24 root steps and two
// 18-step divides through the one shared subtractor, plus multiplies.
// Reset is synchronous and clears config, stick state and control.
// A stalled result sits in the output register; the next item is taken.
// ---------------------------------------------------------------------------
`include "stick_deadzone_cursor_mover_core_assert.svh"

module stick_deadzone_cursor_mover_core (
   input  logic                             clock,
   input  logic                             reset,
   // req_tuser: func
   input  logic                             req_tuser,
   // req_tdata: axis_select, axis_value, now_ms, cursor_x, cursor_y
   input  logic [sdcm_pkg::ReqDataW-1:0]    req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // rsp_tuser: warp_valid
   output logic                             rsp_tuser,
   // rsp_tdata: move_up, move_down, move_left, move_right, release_all,
   //            warp_x, warp_y
   output logic [sdcm_pkg::RspDataW-1:0]    rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [sdcm_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [sdcm_pkg::CsrDataW-1:0]    csr_wdata
);

   localparam int CW = sdcm_pkg::CoordBits;
   localparam int TW = sdcm_pkg::TimeBits;

   // request fields
   logic [1:0]                    f_select;
   logic [sdcm_pkg::AxisW-1:0]    f_value;
   logic [31:0]                   f_now;
   logic [15:0]                   f_cur_x, f_cur_y;

   assign f_select = req_tdata[1:0];
   assign f_value  = req_tdata[17:2];
   assign f_now    = req_tdata[49:18];
   assign f_cur_x  = req_tdata[65:50];
   assign f_cur_y  = req_tdata[81:66];

   // configuration
   logic                          enabled_ff;
   logic [sdcm_pkg::DzW-1:0]      dead_zone_ff;
   logic [15:0]                   repeat_ff, min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         dead_zone_ff <= sdcm_pkg::DeadZoneRst;
         repeat_ff    <= sdcm_pkg::RepeatRst;
         min_x_ff     <= '0;
         min_y_ff     <= '0;
         max_x_ff     <= sdcm_pkg::MaxXRst;
         max_y_ff     <= sdcm_pkg::MaxYRst;
      end else if (csr_we) begin
         case (sdcm_pkg::csr_index_type'(csr_index))
            sdcm_pkg::CSR_ENABLED:   enabled_ff   <= csr_wdata[0];
            sdcm_pkg::CSR_DEAD_ZONE: dead_zone_ff <= csr_wdata[sdcm_pkg::DzW-1:0];
            sdcm_pkg::CSR_REPEAT:    repeat_ff    <= csr_wdata;
            sdcm_pkg::CSR_MIN_X:     min_x_ff     <= csr_wdata;
            sdcm_pkg::CSR_MIN_Y:     min_y_ff     <= csr_wdata;
            sdcm_pkg::CSR_MAX_X:     max_x_ff     <= csr_wdata;
            sdcm_pkg::CSR_MAX_Y:     max_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   logic idle, fin, out_free, accept;

   assign req_tready = idle;
   assign accept     = req_tvalid & idle;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   // stick state
   logic [sdcm_pkg::AxisW-1:0] lx_ff, ly_ff, rx_ff, ry_ff;
   logic [TW-1:0]              last_ff;

   // left stick, right stick and timer decisions
   logic signed [sdcm_pkg::AbsW-1:0] dpos, dneg, lx_s, ly_s, rx_s, ry_s;
   logic [TW-1:0]                    now_t, elapsed;
   logic                             due, up, down, left, right, fire, center;
   logic                             run, ractive;

   assign dpos    = $signed({2'b00, dead_zone_ff});
   assign dneg    = -dpos;
   assign lx_s    = $signed({lx_ff[sdcm_pkg::AxisW-1], lx_ff});
   assign ly_s    = $signed({ly_ff[sdcm_pkg::AxisW-1], ly_ff});
   assign rx_s    = $signed({rx_ff[sdcm_pkg::AxisW-1], rx_ff});
   assign ry_s    = $signed({ry_ff[sdcm_pkg::AxisW-1], ry_ff});
   assign now_t   = TW'(f_now);
   assign elapsed = now_t - last_ff;
   assign due     = (elapsed >= TW'(repeat_ff));
   assign up      = (ly_s < dneg);
   assign down    = (ly_s > dpos);
   assign left    = (lx_s < dneg);
   assign right   = (lx_s > dpos);
   assign fire    = due & (up | down | left | right);
   assign center  = (lx_s > dneg) && (lx_s < dpos) && (ly_s > dneg) && (ly_s < dpos);
   assign ractive = (rx_s > dpos) || (rx_s < dneg) || (ry_s > dpos) || (ry_s < dneg);
   assign run     = req_tuser & enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff   <= '0;
         ly_ff   <= '0;
         rx_ff   <= '0;
         ry_ff   <= '0;
         last_ff <= '0;
      end else if (accept) begin
         if (!req_tuser) begin
            case (f_select)
               2'd0:    lx_ff <= f_value;
               2'd1:    ly_ff <= f_value;
               2'd2:    rx_ff <= f_value;
               default: ry_ff <= f_value;
            endcase
         end else if (run && fire) begin
            last_ff <= now_t;
         end
      end
   end

   // per-item result fields held while the datapath runs
   logic [4:0]    flags_ff;
   logic          warp_ff;
   logic [CW-1:0] cur_x_ff, cur_y_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff <= run ? {center, fire & right, fire & left, fire & down, fire & up}
                         : 5'd0;
         warp_ff  <= run & ractive;
         cur_x_ff <= f_cur_x[CW-1:0];
         cur_y_ff <= f_cur_y[CW-1:0];
      end
   end

   // sequencer and shared datapath
   sdcm_pkg::ctrl_type            ctrl;
   logic [sdcm_pkg::QuotW-1:0]    qx, qy;

   sdcm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .go_long  (accept & run & ractive),
      .go_short (accept & ~(run & ractive)),
      .out_free (out_free),
      .ctrl     (ctrl),
      .idle     (idle),
      .fin      (fin)
   );

   sdcm_dp u_dp (
      .clock     (clock),
      .ctrl      (ctrl),
      .rx        (rx_ff),
      .ry        (ry_ff),
      .dead_zone (dead_zone_ff),
      .qx        (qx),
      .qy        (qy)
   );

   // add signed offset, clamp low then high
   function automatic logic [CW-1:0] place(
      input logic [CW-1:0]              cur,
      input logic [sdcm_pkg::QuotW-1:0] q,
      input logic                       neg,
      input logic [CW-1:0]              lo,
      input logic [CW-1:0]              hi
   );
      logic signed [sdcm_pkg::PlaceW-1:0] off, n, lo_s, hi_s;
      off  = $signed({{(sdcm_pkg::PlaceW - sdcm_pkg::QuotW){1'b0}}, q});
      off  = neg ? -off : off;
      lo_s = $signed({{(sdcm_pkg::PlaceW - CW){1'b0}}, lo});
      hi_s = $signed({{(sdcm_pkg::PlaceW - CW){1'b0}}, hi});
      n    = $signed({{(sdcm_pkg::PlaceW - CW){1'b0}}, cur}) + off;
      if (n < lo_s) begin
         n = lo_s;
      end
      if (n > hi_s) begin
         n = hi_s;
      end
      return n[CW-1:0];
   endfunction

   logic [CW-1:0] px, py;
   logic [15:0]   warp_x, warp_y;

   assign px     = place(cur_x_ff, qx, rx_ff[sdcm_pkg::AxisW-1],
                         min_x_ff[CW-1:0], max_x_ff[CW-1:0]);
   assign py     = place(cur_y_ff, qy, ry_ff[sdcm_pkg::AxisW-1],
                         min_y_ff[CW-1:0], max_y_ff[CW-1:0]);
   assign warp_x = warp_ff ? 16'(px) : 16'd0;
   assign warp_y = warp_ff ? 16'(py) : 16'd0;

   // output register
   logic                          rsp_tvalid_ff;
   logic                          rsp_tuser_ff;
   logic [sdcm_pkg::RspDataW-1:0] rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (fin) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_tuser_ff <= warp_ff;
         rsp_tdata_ff <= {3'd0, warp_y, warp_x, flags_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // checks
   `SDCM_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   `SDCM_ASSERT_IMP(a_release_excl, clock, reset, rsp_tvalid, !(rsp_tdata[4] && (rsp_tdata[3:0] != 4'd0)))
   `SDCM_ASSERT_IMP(a_up_down_excl, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]))
   `SDCM_ASSERT_IMP(a_nowarp_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[36:5] == 32'd0)

endmodule
